// ===== rtl/fgr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the glyph renderer.
`timescale 1ns / 1ps
package fgr_pkg;

  localparam int CHAR_PITCH_DEF = 6;

  localparam int CODE_W    = 8;
  localparam int COORD_W   = 12;
  localparam int POS_W     = 13;   // cursor plus dot offset
  localparam int SCALE_W   = 4;
  localparam int SCREEN_W  = 11;
  localparam int RECT_XY_W = 10;
  localparam int COLOR_W   = 16;
  localparam int GLYPH_N   = 35;
  localparam int GLYPH_IDX_W = 6;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SCALE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd3;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX = 11'd1024;
  localparam logic [COORD_W-1:0]  CURSOR_MAX = 12'd4095;

  localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CASE_FOLD  = 8'h40;  // 'a' - ('A' - ' ')

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic [RECT_XY_W-1:0] x;
    logic [RECT_XY_W-1:0] y;
    logic [SCALE_W-1:0]   w;
    logic [SCALE_W-1:0]   h;
    logic [COLOR_W-1:0]   color;
  } rect_t;

  typedef struct packed {
    logic push;
    logic flush;
  } emit_ctrl_t;

  typedef struct packed {
    logic can_push;
    logic pend_valid;
  } emit_stat_t;

  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] d;
    d = '0;
    if (code >= CH_SPACE && code <= CH_UPPER_Z) d = code - CH_SPACE;
    else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) d = code - CASE_FOLD;
    return d[GLYPH_IDX_W-1:0];
  endfunction

  // column c occupies bits [7c+6:7c], bit 0 of a column is the top row
  function automatic logic [GLYPH_N-1:0] pack5(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3,
                                               input logic [7:0] c4);
    return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  function automatic logic [GLYPH_N-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
    logic [GLYPH_N-1:0] g;
    case (idx)
      6'd1:  g = pack5(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      6'd2:  g = pack5(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
      6'd3:  g = pack5(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
      6'd4:  g = pack5(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
      6'd5:  g = pack5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      6'd6:  g = pack5(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
      6'd7:  g = pack5(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
      6'd8:  g = pack5(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
      6'd9:  g = pack5(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
      6'd10: g = pack5(8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08);
      6'd11: g = pack5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      6'd12: g = pack5(8'h00, 8'h50, 8'h30, 8'h00, 8'h00);
      6'd13: g = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      6'd14: g = pack5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      6'd15: g = pack5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      6'd16: g = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      6'd17: g = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      6'd18: g = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      6'd19: g = pack5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      6'd20: g = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      6'd21: g = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      6'd22: g = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      6'd23: g = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      6'd24: g = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd25: g = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      6'd26: g = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      6'd27: g = pack5(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
      6'd28: g = pack5(8'h00, 8'h08, 8'h14, 8'h22, 8'h41);
      6'd29: g = pack5(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
      6'd30: g = pack5(8'h41, 8'h22, 8'h14, 8'h08, 8'h00);
      6'd31: g = pack5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
      6'd32: g = pack5(8'h32, 8'h49, 8'h79, 8'h41, 8'h3E);
      6'd33: g = pack5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      6'd34: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd35: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      6'd36: g = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      6'd37: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      6'd38: g = pack5(8'h7F, 8'h09, 8'h09, 8'h01, 8'h01);
      6'd39: g = pack5(8'h3E, 8'h41, 8'h41, 8'h51, 8'h32);
      6'd40: g = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      6'd41: g = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      6'd42: g = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      6'd43: g = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      6'd44: g = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      6'd45: g = pack5(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
      6'd46: g = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      6'd47: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      6'd48: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      6'd49: g = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      6'd50: g = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      6'd51: g = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      6'd52: g = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      6'd53: g = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      6'd54: g = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      6'd55: g = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      6'd56: g = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      6'd57: g = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      6'd58: g = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/fgr_clip.sv =====
// Dot square clipper: drops squares off the screen and cuts those crossing an edge.
`timescale 1ns / 1ps
module fgr_clip (
  input  logic [fgr_pkg::POS_W-1:0]    x_pos,
  input  logic [fgr_pkg::POS_W-1:0]    y_pos,
  input  logic [fgr_pkg::SCALE_W-1:0]  scale,
  input  logic [fgr_pkg::SCREEN_W-1:0] scr_w,
  input  logic [fgr_pkg::SCREEN_W-1:0] scr_h,
  output logic                         hit,
  output logic [fgr_pkg::SCALE_W-1:0]  w,
  output logic [fgr_pkg::SCALE_W-1:0]  h
);
  import fgr_pkg::*;

  logic [POS_W:0] x_end;
  logic [POS_W:0] y_end;
  logic [POS_W:0] w_room;
  logic [POS_W:0] h_room;

  always_comb begin
    x_end  = {1'b0, x_pos} + {{(POS_W+1-SCALE_W){1'b0}}, scale};
    y_end  = {1'b0, y_pos} + {{(POS_W+1-SCALE_W){1'b0}}, scale};
    w_room = {{(POS_W+1-SCREEN_W){1'b0}}, scr_w} - {1'b0, x_pos};
    h_room = {{(POS_W+1-SCREEN_W){1'b0}}, scr_h} - {1'b0, y_pos};
    hit = (scale != '0) && ({1'b0, x_pos} < {{(POS_W+1-SCREEN_W){1'b0}}, scr_w})
                        && ({1'b0, y_pos} < {{(POS_W+1-SCREEN_W){1'b0}}, scr_h});
    // room is below scale whenever the square crosses the edge
    w = (x_end > {{(POS_W+1-SCREEN_W){1'b0}}, scr_w}) ? w_room[SCALE_W-1:0] : scale;
    h = (y_end > {{(POS_W+1-SCREEN_W){1'b0}}, scr_h}) ? h_room[SCALE_W-1:0] : scale;
  end

endmodule

// ===== rtl/fgr_emit.sv =====
// Result stage: one held-back square to mark the last one, then the output register.
`timescale 1ns / 1ps
module fgr_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  fgr_pkg::emit_ctrl_t               ctrl,
  input  fgr_pkg::rect_t                    push_rect,
  output fgr_pkg::emit_stat_t               stat,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fgr_pkg::OUT_DATA_W-1:0]    m_tdata,  // rect_x, rect_y, rect_w, rect_h, rect_color, zero pad
  output logic                              m_tlast   // last_rect
);
  import fgr_pkg::*;

  rect_t pend;
  logic  pend_valid;
  rect_t out_rect;
  logic  out_last;
  logic  out_free;
  logic  load_out;

  assign out_free       = !m_tvalid || m_tready;
  assign stat.can_push  = !pend_valid || out_free;
  assign stat.pend_valid = pend_valid;
  // held square moves on when a newer one arrives or the character ends
  assign load_out       = pend_valid && out_free && (ctrl.push || ctrl.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load_out) begin
        out_rect <= pend;
        out_last <= !ctrl.push;
      end
      if (ctrl.push && (!pend_valid || out_free)) begin
        pend       <= push_rect;
        pend_valid <= 1'b1;
      end else if (ctrl.flush && pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W-2*RECT_XY_W-2*SCALE_W-COLOR_W){1'b0}},
                    out_rect.color, out_rect.h, out_rect.w, out_rect.y, out_rect.x};
  assign m_tlast = out_last;

endmodule

// ===== rtl/font_glyph_rect_renderer_core.sv =====
// Top level of the glyph renderer: registers, cursor and dot sequencer.
`timescale 1ns / 1ps
// Draws one character per input request as filled squares, one per set dot of a 5x7
// column font, walked column by column and top row first, each square glyph_scale on a
// side in text_color and clipped to the screen. begin_string (tuser) loads the cursor from
// start_x/start_y first; afterwards the cursor moves right by CHAR_PITCH*glyph_scale,
// saturating at 4095. A character is accepted, then the dot sequencer checks one dot a
// cycle through the single clip unit, except while a visible dot waits for the held
// square to move on; then the held-back last square is released and the cursor steps,
// with nothing held back for a character with no visible dot. Output back-pressure stalls
// these steps; the input is not ready until the cursor has stepped. m_tlast marks a
// character's final square; a character with no visible dot gives no request at all.
module font_glyph_rect_renderer_core #(
  parameter int CHAR_PITCH = fgr_pkg::CHAR_PITCH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fgr_pkg::IN_DATA_W-1:0]    s_tdata,   // char_code, start_x, start_y
  input  logic                             s_tuser,   // begin_string
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fgr_pkg::OUT_DATA_W-1:0]   m_tdata,   // rect_x, rect_y, rect_w, rect_h, rect_color, zero pad
  output logic                             m_tlast,   // last_rect
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fgr_pkg::*;

  localparam int ADV_MAX = CHAR_PITCH * 15;
  localparam int ADV_W   = $clog2(ADV_MAX + 1);
  localparam logic [ADV_W-1:0] PITCH = ADV_W'(CHAR_PITCH);
  localparam logic [2:0] LAST_ROW = 3'd6;
  localparam logic [2:0] LAST_COL = 3'd4;

  typedef enum logic [1:0] {IDLE, RUN, FLUSH} state_t;

  state_t state;
  logic [COLOR_W-1:0]  text_color;
  logic [SCALE_W-1:0]  glyph_scale;
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [COORD_W-1:0]  cursor_x;
  logic [COORD_W-1:0]  cursor_y;
  logic [POS_W-1:0]    x_pos;
  logic [POS_W-1:0]    y_pos;
  logic [2:0]          col;
  logic [2:0]          row;
  logic [GLYPH_N-1:0]  glyph;

  logic [CODE_W-1:0]   in_code;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic [COORD_W-1:0]  base_x;
  logic [COORD_W-1:0]  base_y;
  logic [SCREEN_W-1:0] scr_w;
  logic [SCREEN_W-1:0] scr_h;
  logic                hit;
  logic [SCALE_W-1:0]  clip_w;
  logic [SCALE_W-1:0]  clip_h;
  logic                dot_on;
  logic                step;
  logic [ADV_W-1:0]    advance;
  logic [COORD_W:0]    cursor_x_next;
  emit_ctrl_t          ctrl;
  emit_stat_t          stat;
  rect_t               rect;

  assign in_code = s_tdata[CODE_W-1:0];
  assign in_x    = s_tdata[CODE_W+COORD_W-1:CODE_W];
  assign in_y    = s_tdata[CODE_W+2*COORD_W-1:CODE_W+COORD_W];
  assign base_x  = s_tuser ? in_x : cursor_x;
  assign base_y  = s_tuser ? in_y : cursor_y;

  assign scr_w = (screen_width  > SCREEN_MAX) ? SCREEN_MAX : screen_width;
  assign scr_h = (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  fgr_clip u_clip (
    .x_pos (x_pos),
    .y_pos (y_pos),
    .scale (glyph_scale),
    .scr_w (scr_w),
    .scr_h (scr_h),
    .hit   (hit),
    .w     (clip_w),
    .h     (clip_h)
  );

  assign dot_on     = glyph[0] && hit;
  // a visible dot waits while the held square cannot move on
  assign step       = (state == RUN) && (!dot_on || stat.can_push);
  assign ctrl.push  = (state == RUN) && dot_on;
  assign ctrl.flush = (state == FLUSH);

  assign rect.x     = x_pos[RECT_XY_W-1:0];
  assign rect.y     = y_pos[RECT_XY_W-1:0];
  assign rect.w     = clip_w;
  assign rect.h     = clip_h;
  assign rect.color = text_color;

  assign advance       = PITCH * ADV_W'(glyph_scale);
  assign cursor_x_next = {1'b0, cursor_x} + (COORD_W+1)'(advance);

  fgr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .push_rect (rect),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      text_color    <= 16'hFFFF;
      glyph_scale   <= 4'd1;
      screen_width  <= 11'd240;
      screen_height <= 11'd320;
      cursor_x      <= '0;
      cursor_y      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TEXT_COLOR:    text_color    <= cfg_data;
          REG_GLYPH_SCALE:   glyph_scale   <= cfg_data[SCALE_W-1:0];
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SCREEN_W-1:0];
          REG_SCREEN_HEIGHT: screen_height <= cfg_data[SCREEN_W-1:0];
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cursor_x <= base_x;
            cursor_y <= base_y;
            x_pos    <= {1'b0, base_x};
            y_pos    <= {1'b0, base_y};
            col      <= '0;
            row      <= '0;
            glyph    <= glyph_bits(glyph_index(in_code));
            state    <= RUN;
          end
        end
        RUN: begin
          if (step) begin
            glyph <= glyph >> 1;
            if (row == LAST_ROW) begin
              row   <= '0;
              col   <= col + 3'd1;
              y_pos <= {1'b0, cursor_y};
              x_pos <= x_pos + POS_W'(glyph_scale);
              if (col == LAST_COL) state <= FLUSH;
            end else begin
              row   <= row + 3'd1;
              y_pos <= y_pos + POS_W'(glyph_scale);
            end
          end
        end
        FLUSH: begin
          if (!stat.pend_valid) begin
            cursor_x <= (cursor_x_next > {1'b0, CURSOR_MAX}) ? CURSOR_MAX
                                                             : cursor_x_next[COORD_W-1:0];
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fgr_checker.sv =====
// Port-level checks on the glyph renderer, bound to its top level.
`timescale 1ns / 1ps
module fgr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fgr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import fgr_pkg::*;

  // a stalled square stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request dropped or changed while stalled");

  // a character keeps the input closed while it is drawn
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request was taken");

  // clipped squares never have zero size
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:20] != 4'd0) && (m_tdata[27:24] != 4'd0))
    else $error("empty square emitted");

  // no square left over from before reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind font_glyph_rect_renderer_core fgr_checker u_fgr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
